FILE: hdl/sof_length_checksum_deframer_assert.svh
// Assertion macros for the start/length/checksum deframer.
// Included by the top level; needs nothing else.
`ifndef SOF_LENGTH_CHECKSUM_DEFRAMER_ASSERT_SVH
`define SOF_LENGTH_CHECKSUM_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define SOFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, disabled while the active-low reset is asserted.
`define SOFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

FILE: hdl/sofd_pkg.sv
// Shared types and constants of the start/length/checksum deframer.
// No dependencies.
package sofd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TMO_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'hAA;
  localparam logic [BYTE_W-1:0] MAX_LENGTH_RST = 8'hFF;
  localparam logic [TMO_W-1:0]  TIMEOUT_RST = 16'h0FFF;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd1;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SUM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd3;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_SUM  = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] max_length;
    logic [TMO_W-1:0]  timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   payload_byte;
    logic [BYTE_W-1:0]   byte_index;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   frame_length;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
    logic [1:0] phase;
  } core_res_t;

endpackage

FILE: hdl/sofd_if.sv
// Valid/ready channel interfaces of the deframer: input words, result
// words and configuration writes. Depends on sofd_pkg.
interface sofd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [sofd_pkg::BYTE_W-1:0] rx_byte;
  modport source (output valid, cmd, rx_byte, input ready);
  modport sink (input valid, cmd, rx_byte, output ready);
endinterface

interface sofd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [sofd_pkg::BYTE_W-1:0]   payload_byte;
  logic [sofd_pkg::BYTE_W-1:0]   byte_index;
  logic [sofd_pkg::STATUS_W-1:0] status;
  logic [sofd_pkg::BYTE_W-1:0]   frame_length;
  modport source (output valid, kind, payload_byte, byte_index, status, frame_length,
                  input ready);
  modport sink (input valid, kind, payload_byte, byte_index, status, frame_length,
                output ready);
endinterface

interface sofd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sofd_pkg::CFG_IDX_W-1:0] index;
  logic [sofd_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/sofd_cfg.sv
// Configuration registers of the deframer: maximum length and timeout.
// Depends on sofd_pkg.
module sofd_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [sofd_pkg::CFG_IDX_W-1:0] wr_idx_i,
  input  logic [sofd_pkg::CFG_DAT_W-1:0] wr_data_i,
  output sofd_pkg::cfg_t                 cfg_o
);
  import sofd_pkg::*;

  logic [BYTE_W-1:0] max_length_q, max_length_d;
  logic [TMO_W-1:0]  timeout_q, timeout_d;

  always_comb begin
    max_length_d = max_length_q;
    timeout_d    = timeout_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        REG_MAX_LENGTH: max_length_d = wr_data_i[BYTE_W-1:0];
        REG_TIMEOUT:    timeout_d    = wr_data_i[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MAX_LENGTH_RST;
      timeout_q    <= TIMEOUT_RST;
    end else begin
      max_length_q <= max_length_d;
      timeout_q    <= timeout_d;
    end
  end

  assign cfg_o.max_length    = max_length_q;
  assign cfg_o.timeout_ticks = timeout_q;
endmodule

FILE: hdl/sofd_in_reg.sv
// Input register of the deframer: holds one accepted word until the
// frame logic takes it. Depends on sofd_pkg.
module sofd_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sofd_pkg::item_t in_item_i,
  input  logic            advance_i,
  output logic            valid_o,
  output sofd_pkg::item_t item_o
);
  import sofd_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  assign in_ready_o = !valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

FILE: hdl/sofd_core.sv
// Frame state machine of the deframer: hunt, length, too-long abort,
// payload, checksum, idle timeout. Depends on sofd_pkg.
module sofd_core #(
  parameter int unsigned CNT_W = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  sofd_pkg::item_t      item_i,
  input  sofd_pkg::cfg_t       cfg_i,
  output sofd_pkg::core_res_t  res_o
);
  import sofd_pkg::*;

  localparam int unsigned CW = (CNT_W > TMO_W) ? CNT_W : TMO_W;
  localparam logic [CNT_W-1:0] CAP = {CNT_W{1'b1}};

  logic [1:0]        phase_q, phase_d;
  logic [BYTE_W-1:0] exp_len_q, exp_len_d;
  logic [BYTE_W-1:0] seen_q, seen_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]  idle_q, idle_d;

  logic [CNT_W-1:0]  idle_inc;
  logic [CW-1:0]     limit;
  logic [BYTE_W-1:0] seen_inc;
  logic [BYTE_W-1:0] b;
  result_t           res;
  logic              emit;

  assign b        = item_i.rx_byte;
  assign seen_inc = seen_q + BYTE_W'(1);
  assign idle_inc = (idle_q == CAP) ? idle_q : idle_q + CNT_W'(1);
  assign limit    = (CW'(cfg_i.timeout_ticks) > CW'(CAP)) ? CW'(CAP)
                                                          : CW'(cfg_i.timeout_ticks);

  always_comb begin
    phase_d   = phase_q;
    exp_len_d = exp_len_q;
    seen_d    = seen_q;
    sum_d     = sum_q;
    idle_d    = idle_q;
    emit      = 1'b0;
    res       = '0;
    if (item_i.cmd == CMD_TICK) begin
      if (phase_q != PH_HUNT) begin
        if (CW'(idle_inc) >= limit) begin
          emit             = 1'b1;
          res.kind         = KIND_END;
          res.status       = ST_TIMEOUT;
          res.frame_length = exp_len_q;
          phase_d          = PH_HUNT;
          idle_d           = '0;
        end else begin
          idle_d = idle_inc;
        end
      end
    end else begin
      idle_d = '0;
      case (phase_q)
        PH_HUNT: begin
          if (b == START_BYTE) begin
            phase_d   = PH_LEN;
            exp_len_d = '0;
            seen_d    = '0;
            sum_d     = '0;
          end
        end
        PH_LEN: begin
          exp_len_d = b;
          sum_d     = b;
          seen_d    = '0;
          if (b > cfg_i.max_length) begin
            emit             = 1'b1;
            res.kind         = KIND_END;
            res.status       = ST_TOO_LONG;
            res.frame_length = b;
            phase_d          = PH_HUNT;
          end else begin
            phase_d = (b == '0) ? PH_SUM : PH_DATA;
          end
        end
        PH_DATA: begin
          emit             = 1'b1;
          res.kind         = KIND_DATA;
          res.payload_byte = b;
          res.byte_index   = seen_q;
          sum_d            = sum_q + b;
          seen_d           = seen_inc;
          if (seen_inc >= exp_len_q) begin
            phase_d = PH_SUM;
          end
        end
        PH_SUM: begin
          emit             = 1'b1;
          res.kind         = KIND_END;
          res.status       = (b == sum_q) ? ST_OK : ST_BAD_SUM;
          res.frame_length = exp_len_q;
          phase_d          = PH_HUNT;
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      exp_len_q <= '0;
      seen_q    <= '0;
      sum_q     <= '0;
      idle_q    <= '0;
    end else if (advance_i) begin
      phase_q   <= phase_d;
      exp_len_q <= exp_len_d;
      seen_q    <= seen_d;
      sum_q     <= sum_d;
      idle_q    <= idle_d;
    end
  end

  assign res_o.emit  = emit;
  assign res_o.res   = res;
  assign res_o.phase = phase_q;
endmodule

FILE: hdl/sofd_out_reg.sv
// Result register of the deframer: holds one result word until the
// downstream side takes it. Depends on sofd_pkg.
module sofd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  sofd_pkg::result_t res_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              free_o,
  output sofd_pkg::result_t res_o
);
  import sofd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;
endmodule

FILE: hdl/sof_length_checksum_deframer.sv
// Top level of the start/length/checksum deframer.
// Depends on sofd_pkg, sofd_if, sofd_cfg, sofd_in_reg, sofd_core, sofd_out_reg.
//
//   channel  direction  word contents
//   in_i     sink       cmd, rx_byte
//   out_o    source     kind, payload_byte, byte_index, status, frame_length
//   cfg_i    sink       index, data (always ready)
//
// One word per cycle unless stalled: input register, frame logic, result
// register. Input words are registered before the frame logic sees them.
// Frame logic advances on a held word if result register is empty or drained.
// A stalled result register backs up into the input register, then in_i.ready.
// Reset clears state; no clearing pass.
`include "sof_length_checksum_deframer_assert.svh"

module sof_length_checksum_deframer #(
  parameter int unsigned IDLE_COUNTER_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sofd_in_if.sink   in_i,
  sofd_out_if.source out_o,
  sofd_cfg_if.sink  cfg_i
);
  import sofd_pkg::*;

  cfg_t      cfg;
  item_t     in_item;
  item_t     cur_item;
  logic      cur_valid;
  logic      out_free;
  logic      advance;
  core_res_t core_res;
  result_t   out_res;

  assign cfg_i.ready = 1'b1;

  sofd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  assign in_item.cmd     = in_i.cmd;
  assign in_item.rx_byte = in_i.rx_byte;

  sofd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_item_i  (in_item),
    .advance_i  (advance),
    .valid_o    (cur_valid),
    .item_o     (cur_item)
  );

  assign advance = cur_valid && out_free;

  sofd_core #(
    .CNT_W (IDLE_COUNTER_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (cur_item),
    .cfg_i     (cfg),
    .res_o     (core_res)
  );

  sofd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && core_res.emit),
    .res_i       (core_res.res),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .free_o      (out_free),
    .res_o       (out_res)
  );

  assign out_o.kind         = out_res.kind;
  assign out_o.payload_byte = out_res.payload_byte;
  assign out_o.byte_index   = out_res.byte_index;
  assign out_o.status       = out_res.status;
  assign out_o.frame_length = out_res.frame_length;

  `SOFD_ASSERT_NEXT(a_emit_loads, clk_i, rst_ni, advance && core_res.emit, out_o.valid)
  `SOFD_ASSERT_NEXT(a_end_hunts, clk_i, rst_ni,
                    advance && core_res.emit && core_res.res.kind == KIND_END,
                    core_res.phase == PH_HUNT)
  `SOFD_ASSERT_NEXT(a_data_in_frame, clk_i, rst_ni,
                    advance && core_res.emit && core_res.res.kind == KIND_DATA,
                    core_res.phase == PH_DATA || core_res.phase == PH_SUM)
  `SOFD_ASSERT_NEXT(a_item_held, clk_i, rst_ni, cur_valid && !advance, cur_valid)
  `SOFD_ASSERT_NOW(a_no_adv_when_full, clk_i, rst_ni, out_o.valid && !out_o.ready, !advance)

endmodule

FILE: bench/sof_length_checksum_deframer_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for sof_length_checksum_deframer: byte and tick words are
// predicted by a software copy of the frame logic and every result word is compared.
// Depends on sofd_pkg and the channel interfaces in sofd_if.
module sof_length_checksum_deframer_tb;
  import sofd_pkg::*;

  localparam int unsigned IDLE_BITS     = 16;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_WORDS   = 290;

  logic clk_i = 1'b0;
  logic rst_ni;

  sofd_in_if  in_ch ();
  sofd_out_if out_ch ();
  sofd_cfg_if cfg_ch ();

  sof_length_checksum_deframer #(.IDLE_COUNTER_BITS(IDLE_BITS)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  cfg_t        cfg_model;
  logic [1:0]  fr_phase;
  logic [7:0]  fr_len;
  logic [7:0]  fr_count;
  logic [7:0]  fr_sum;
  logic [63:0] idle_ticks;

  item_t       pending_words[$];
  result_t     expected_results[$];
  int unsigned words_queued;
  int unsigned words_sent;
  int unsigned errors;
  int unsigned data_seen;
  int unsigned ends_seen[4];
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void close_frame(logic [STATUS_W-1:0] st, logic [7:0] len);
    result_t r;
    r = '0;
    r.kind = KIND_END;
    r.status = st;
    r.frame_length = len;
    expected_results.push_back(r);
    fr_phase = PH_HUNT;
    idle_ticks = '0;
  endfunction

  function automatic void deframe_step(item_t w);
    result_t r;
    logic [63:0] cap;
    logic [63:0] limit;
    cap = (64'd1 << IDLE_BITS) - 64'd1;
    if (w.cmd == CMD_TICK) begin
      if (fr_phase != PH_HUNT) begin
        limit = (64'(cfg_model.timeout_ticks) > cap) ? cap : 64'(cfg_model.timeout_ticks);
        if (idle_ticks < cap) idle_ticks++;
        if (idle_ticks >= limit) close_frame(ST_TIMEOUT, fr_len);
      end
    end else begin
      idle_ticks = '0;
      case (fr_phase)
        PH_HUNT: if (w.rx_byte == START_BYTE) begin
          fr_phase = PH_LEN;
          fr_len = '0;
          fr_count = '0;
          fr_sum = '0;
        end
        PH_LEN: begin
          fr_len = w.rx_byte;
          fr_sum = w.rx_byte;
          fr_count = '0;
          if (w.rx_byte > cfg_model.max_length) close_frame(ST_TOO_LONG, w.rx_byte);
          else fr_phase = (w.rx_byte == 8'd0) ? PH_SUM : PH_DATA;
        end
        PH_DATA: begin
          r = '0;
          r.kind = KIND_DATA;
          r.payload_byte = w.rx_byte;
          r.byte_index = fr_count;
          expected_results.push_back(r);
          fr_sum = fr_sum + w.rx_byte;
          fr_count = fr_count + 8'd1;
          if (fr_count >= fr_len) fr_phase = PH_SUM;
        end
        default: close_frame((w.rx_byte == fr_sum) ? ST_OK : ST_BAD_SUM, fr_len);
      endcase
    end
  endfunction

  function automatic void push_word(logic cmd, logic [7:0] b);
    pending_words.push_back(item_t'{cmd, b});
    words_queued++;
  endfunction

  function automatic void push_ticks(int unsigned n);
    repeat (n) push_word(CMD_TICK, 8'($urandom));
  endfunction

  // occasionally hold the line long enough to trip the idle abort
  function automatic void maybe_idle();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3 && cfg_model.timeout_ticks <= 16'd64)
      push_ticks(int'(cfg_model.timeout_ticks) + $urandom_range(1));
    else if (r < 15)
      push_ticks($urandom_range(1, 2));
  endfunction

  function automatic void push_random_frame();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  sum;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 4)) push_word(1'($urandom_range(1)), 8'($urandom));
      return;
    end
    len = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(12);
    sum = 8'(len);
    push_word(CMD_BYTE, START_BYTE);
    maybe_idle();
    push_word(CMD_BYTE, 8'(len));
    for (int unsigned i = 0; i < len; i++) begin
      maybe_idle();
      b = ($urandom_range(15) == 0) ? START_BYTE : 8'($urandom);
      sum = sum + b;
      push_word(CMD_BYTE, b);
    end
    maybe_idle();
    // drop the checksum: the next frame's words run into this one
    if (pick >= 20 && pick < 25) return;
    push_word(CMD_BYTE, (pick < 20) ? (sum ^ 8'($urandom_range(1, 255))) : sum);
  endfunction

  task automatic wait_drain();
    while (words_sent != words_queued || expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_MAX_LENGTH: cfg_model.max_length = val[BYTE_W-1:0];
      REG_TIMEOUT:    cfg_model.timeout_ticks = val;
      default: ;
    endcase
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : drive_words
    item_t nxt;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        deframe_step(item_t'{in_ch.cmd, in_ch.rx_byte});
        words_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = pending_words.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.cmd     <= nxt.cmd;
          in_ch.rx_byte <= nxt.rx_byte;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watch_results
    result_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual kind %0d byte %h index %0d status %0d length %0d",
                   $time, out_ch.kind, out_ch.payload_byte, out_ch.byte_index, out_ch.status,
                   out_ch.frame_length);
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, out_ch.kind);
          check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
          check_field("byte_index", want.byte_index, out_ch.byte_index);
          check_field("status", want.status, out_ch.status);
          check_field("frame_length", want.frame_length, out_ch.frame_length);
          if (want.kind == KIND_DATA) data_seen++;
          else ends_seen[want.status]++;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  initial begin
    logic [CFG_DAT_W-1:0] len_cfg[PHASES] = '{16'h0000, 16'hA5FF, 16'h0008, 16'h0014,
                                               16'h7F64, 16'h00FF};
    logic [CFG_DAT_W-1:0] tmo_cfg[PHASES] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0003,
                                               16'h0011, 16'h0FFF};
    int unsigned idle_pct[4]  = '{0, 53, 0, 37};
    int unsigned stall_pct[4] = '{0, 0, 53, 37};
    int unsigned start;

    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_BYTE;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_MAX_LENGTH;
    cfg_ch.data   = '0;
    rst_ni        = 1'b0;

    cfg_model.max_length    = MAX_LENGTH_RST;
    cfg_model.timeout_ticks = TIMEOUT_RST;
    fr_phase   = PH_HUNT;
    fr_len     = '0;
    fr_count   = '0;
    fr_sum     = '0;
    idle_ticks = '0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // hunting noise, zero length, start byte as payload, bad sum, ticks inside a frame
    push_word(CMD_TICK, 8'hFF);
    push_word(CMD_BYTE, 8'h00);
    push_word(CMD_BYTE, 8'hFF);
    push_word(CMD_BYTE, 8'h55);
    push_word(CMD_BYTE, START_BYTE); push_word(CMD_BYTE, 8'h00); push_word(CMD_BYTE, 8'h00);
    push_word(CMD_BYTE, START_BYTE); push_word(CMD_BYTE, 8'h02);
    push_word(CMD_BYTE, START_BYTE); push_word(CMD_BYTE, 8'hFF); push_word(CMD_BYTE, 8'hAB);
    push_word(CMD_BYTE, START_BYTE); push_word(CMD_BYTE, 8'h01);
    push_word(CMD_BYTE, 8'h00); push_word(CMD_BYTE, 8'h00);
    push_word(CMD_BYTE, START_BYTE); push_word(CMD_BYTE, 8'h03); push_word(CMD_BYTE, 8'h10);
    push_ticks(2);
    push_word(CMD_BYTE, 8'h20); push_word(CMD_BYTE, 8'h30); push_word(CMD_BYTE, 8'h63);
    wait_drain();

    for (int unsigned p = 0; p < PHASES; p++) begin
      src_idle_pct  = idle_pct[p % 4];
      snk_stall_pct = stall_pct[p % 4];
      write_reg(REG_MAX_LENGTH, len_cfg[p]);
      write_reg(REG_TIMEOUT, tmo_cfg[p]);
      if (p == 3) begin
        write_reg(2'd2, 16'($urandom));
        write_reg(2'd3, 16'($urandom));
      end
      if (p == 0) begin
        // too long, and idle aborts in the length and checksum states
        push_word(CMD_BYTE, START_BYTE); push_word(CMD_BYTE, 8'h01);
        push_word(CMD_BYTE, START_BYTE); push_word(CMD_TICK, 8'h00);
        push_word(CMD_BYTE, START_BYTE); push_word(CMD_BYTE, 8'h00); push_word(CMD_TICK, 8'hFF);
      end
      start = words_queued;
      while (words_queued - start < PHASE_WORDS / 2) push_random_frame();
      wait_drain();
      while (words_queued - start < PHASE_WORDS) push_random_frame();
      wait_drain();
    end

    $display("Covered %0d input words and %0d payload words under %0d register settings",
             words_sent, data_seen, PHASES + 1);
    $display("Frame ends: %0d good, %0d bad checksum, %0d too long, %0d timed out",
             ends_seen[ST_OK], ends_seen[ST_BAD_SUM], ends_seen[ST_TOO_LONG],
             ends_seen[ST_TIMEOUT]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
